[rtl/lgs_pkg.sv]
// Shared types and constants of the Laplace Gauss-Seidel relaxation block.
// Used by lgs_ctrl, lgs_dpath and laplace_gauss_seidel_relaxation; no dependencies.
package lgs_pkg;

   // grid geometry
   localparam int GRID_MAX_DEF = 64;
   localparam int SIDE_MIN     = 3;

   // cell constants, signed Q15.16
   localparam logic [31:0] CELL_ZERO    = 32'h0000_0000;
   localparam logic [31:0] CELL_ONE     = 32'h0001_0000;
   localparam logic [31:0] CELL_HUNDRED = 32'h0064_0000;

   // configuration register indexes (byte address bit 2)
   localparam logic REG_GRID_SIZE   = 1'b0;
   localparam logic REG_SWEEP_COUNT = 1'b1;

   // configuration reset values
   localparam logic [6:0]  GRID_SIZE_RST   = 7'd10;
   localparam logic [15:0] SWEEP_COUNT_RST = 16'd200;

   // result kinds
   localparam logic RSP_READ = 1'b0;
   localparam logic RSP_DONE = 1'b1;

   // request codes
   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_READ  = 2'd1,
      REQ_SWEEP = 2'd2,
      REQ_INIT  = 2'd3
   } req_kind_type;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_READ_RSP,
      ST_INIT,
      ST_SWEEP_LEFT,
      ST_SWEEP_UP,
      ST_SWEEP_DOWN,
      ST_SWEEP_RIGHT,
      ST_SWEEP_WRITE,
      ST_DONE
   } state_type;

   // which address the grid memory read port takes
   typedef enum logic [2:0] {
      RS_NONE,
      RS_REQ,
      RS_LEFT,
      RS_UP,
      RS_DOWN,
      RS_RIGHT
   } rd_sel_type;

   // controller to datapath
   typedef struct packed {
      logic       capture;
      logic       host_write;
      logic       init_first;
      logic       init_write;
      logic       sweep_first;
      logic       relax_write;
      rd_sel_type read_sel;
      logic       rsp_load;
      logic       rsp_kind;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic in_grid;
      logic init_last;
      logic row_end;
      logic pass_cell_last;
      logic pass_last;
      logic passes_zero;
      logic rsp_free;
   } status_type;

endpackage

[rtl/laplace_gauss_seidel_relaxation.sv]
// Top level of the Laplace Gauss-Seidel relaxation block: configuration
// registers and the controller/datapath pair. Depends on lgs_pkg, lgs_ctrl, lgs_dpath.
//
// Holds a GRID_MAX by GRID_MAX grid of signed Q15.16 cells in one memory with a
// single registered read port; the grid side in use is grid_size clamped to
// 3..GRID_MAX. An init item writes all n*n cells. A sweep item runs
// sweep_count passes; each interior cell needs three reads (up, down, right)
// on the one memory read port plus a write, and each row one more read for
// its left edge cell. The grid comes up undefined after reset and needs no
// clearing. One item is worked at a time; a finished result waits in an
// output register while the next item is taken.
module laplace_gauss_seidel_relaxation
   import lgs_pkg::*;
#(
   parameter int GRID_MAX = GRID_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [5:0]  req_row,
   input  logic [5:0]  req_col,
   input  logic [31:0] req_write_value,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [31:0] rsp_read_value,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [6:0]  grid_size_ff, grid_size_in;
   logic [15:0] sweep_count_ff, sweep_count_in;
   logic        csr_write;
   cmd_type     cmd;
   status_type  status;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   // configuration register writes
   always_comb begin
      grid_size_in   = grid_size_ff;
      sweep_count_in = sweep_count_ff;
      if (csr_write) begin
         unique case (paddr[2])
            REG_GRID_SIZE:   grid_size_in   = pwdata[6:0];
            REG_SWEEP_COUNT: sweep_count_in = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff   <= GRID_SIZE_RST;
         sweep_count_ff <= SWEEP_COUNT_RST;
      end else begin
         grid_size_ff   <= grid_size_in;
         sweep_count_ff <= sweep_count_in;
      end
   end

   // configuration readback
   always_comb begin
      unique case (paddr[2])
         REG_GRID_SIZE:   prdata = {25'd0, grid_size_ff};
         REG_SWEEP_COUNT: prdata = {16'd0, sweep_count_ff};
         default:         prdata = '0;
      endcase
   end

   lgs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lgs_dpath #(
      .GRID_MAX (GRID_MAX)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .grid_size       (grid_size_ff),
      .sweep_count     (sweep_count_ff),
      .req_row         (req_row),
      .req_col         (req_col),
      .req_write_value (req_write_value),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_read_value  (rsp_read_value)
   );

endmodule

[rtl/lgs_ctrl.sv]
// Controller state machine of the relaxation block: sequences requests,
// init walks and sweeps. Depends on lgs_pkg; drives lgs_dpath by commands.
module lgs_ctrl
   import lgs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_type,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type    state_ff, state_in;
   req_kind_type kind;
   logic         accept;

   assign kind      = req_kind_type'(req_type);
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (kind)
                  REQ_WRITE: state_in = ST_WRITE;
                  REQ_READ:  state_in = ST_READ;
                  REQ_SWEEP: state_in = status.passes_zero ? ST_DONE : ST_SWEEP_LEFT;
                  REQ_INIT:  state_in = ST_INIT;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_WRITE:    state_in = ST_IDLE;
         ST_READ:     state_in = ST_READ_RSP;
         ST_READ_RSP: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         ST_INIT: begin
            if (status.init_last) state_in = ST_IDLE;
         end
         ST_SWEEP_LEFT:  state_in = ST_SWEEP_UP;
         ST_SWEEP_UP:    state_in = ST_SWEEP_DOWN;
         ST_SWEEP_DOWN:  state_in = ST_SWEEP_RIGHT;
         ST_SWEEP_RIGHT: state_in = ST_SWEEP_WRITE;
         ST_SWEEP_WRITE: begin
            if (status.pass_cell_last) begin
               state_in = status.pass_last ? ST_DONE : ST_SWEEP_LEFT;
            end else if (status.row_end) begin
               state_in = ST_SWEEP_LEFT;
            end else begin
               state_in = ST_SWEEP_UP;
            end
         end
         ST_DONE: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd = '0;
      cmd.read_sel = RS_NONE;
      cmd.rsp_kind = RSP_READ;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture     = accept;
            cmd.init_first  = accept && (kind == REQ_INIT);
            cmd.sweep_first = accept && (kind == REQ_SWEEP);
         end
         ST_WRITE:       cmd.host_write = 1'b1;
         ST_READ:        cmd.read_sel = RS_REQ;
         ST_READ_RSP: begin
            cmd.rsp_load = status.rsp_free;
            cmd.rsp_kind = RSP_READ;
         end
         ST_INIT:        cmd.init_write = 1'b1;
         ST_SWEEP_LEFT:  cmd.read_sel = RS_LEFT;
         ST_SWEEP_UP:    cmd.read_sel = RS_UP;
         ST_SWEEP_DOWN:  cmd.read_sel = RS_DOWN;
         ST_SWEEP_RIGHT: cmd.read_sel = RS_RIGHT;
         ST_SWEEP_WRITE: cmd.relax_write = 1'b1;
         ST_DONE: begin
            cmd.rsp_load = status.rsp_free;
            cmd.rsp_kind = RSP_DONE;
         end
         default: cmd = '0;
      endcase
   end

endmodule

[rtl/lgs_dpath.sv]
// Datapath of the relaxation block: grid memory, walk counters, stencil adder
// and result register. Depends on lgs_pkg; commanded by lgs_ctrl.
module lgs_dpath
   import lgs_pkg::*;
#(
   parameter int GRID_MAX = GRID_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [6:0]  grid_size,
   input  logic [15:0] sweep_count,
   input  logic [5:0]  req_row,
   input  logic [5:0]  req_col,
   input  logic [31:0] req_write_value,
   input  cmd_type     cmd,
   output status_type  status,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [31:0] rsp_read_value
);

   localparam int DEPTH  = GRID_MAX * GRID_MAX;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int IDX_W  = $clog2(GRID_MAX);
   localparam int N_W    = $clog2(GRID_MAX + 1);

   // grid memory
   logic [31:0] mem [DEPTH];
   logic [31:0] rdata_ff;
   logic [ADDR_W-1:0] raddr, waddr;
   logic [31:0] wdata;
   logic        we;
   rd_sel_type  sel_q_ff;

   // captured request
   logic [5:0]  row_ff, col_ff;
   logic [31:0] wval_ff;

   // walk counters
   logic [IDX_W-1:0] r_ff, r_in, c_ff, c_in;
   logic [15:0]      pass_ff, pass_in;

   // stencil operands
   logic [31:0] left_ff, up_ff, dn_ff;
   logic [33:0] sum;
   logic [31:0] relax_val;
   logic [31:0] init_val;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff;
   logic [31:0] rsp_value_ff;

   logic [N_W-1:0] side;
   logic [31:0]    n_w, r_w, c_w, cur_w, req_w;

   // side length clamped to the supported range
   always_comb begin
      if (32'(grid_size) < SIDE_MIN) begin
         side = N_W'(SIDE_MIN);
      end else if (32'(grid_size) > GRID_MAX) begin
         side = N_W'(GRID_MAX);
      end else begin
         side = N_W'(grid_size);
      end
   end

   assign n_w   = 32'(side);
   assign r_w   = 32'(r_ff);
   assign c_w   = 32'(c_ff);
   assign cur_w = r_w * GRID_MAX + c_w;
   assign req_w = 32'(row_ff) * GRID_MAX + 32'(col_ff);

   // status toward the controller
   assign status.in_grid        = (32'(row_ff) < n_w) && (32'(col_ff) < n_w);
   assign status.init_last      = (r_w == n_w - 32'd1) && (c_w == n_w - 32'd1);
   assign status.row_end        = (c_w == n_w - 32'd2);
   assign status.pass_cell_last = (c_w == n_w - 32'd2) && (r_w == n_w - 32'd2);
   assign status.pass_last      = ((17'(pass_ff) + 17'd1) == 17'(sweep_count));
   assign status.passes_zero    = (sweep_count == 16'd0);
   assign status.rsp_free       = !rsp_valid_ff || rsp_ready;

   // read address select
   always_comb begin
      case (cmd.read_sel)
         RS_REQ:   raddr = status.in_grid ? ADDR_W'(req_w) : '0;
         RS_LEFT:  raddr = ADDR_W'(cur_w - 32'd1);
         RS_UP:    raddr = ADDR_W'(cur_w - 32'(GRID_MAX));
         RS_DOWN:  raddr = ADDR_W'(cur_w + 32'(GRID_MAX));
         RS_RIGHT: raddr = ADDR_W'(cur_w + 32'd1);
         default:  raddr = '0;
      endcase
   end

   // init pattern: top row 100, other edges 0, interior 1
   always_comb begin
      if (r_ff == '0) begin
         init_val = CELL_HUNDRED;
      end else if ((r_w == n_w - 32'd1) || (c_ff == '0) || (c_w == n_w - 32'd1)) begin
         init_val = CELL_ZERO;
      end else begin
         init_val = CELL_ONE;
      end
   end

   // four-neighbor sum, floor divide by four; right neighbor comes straight off the port
   assign sum = {{2{up_ff[31]}}, up_ff} + {{2{dn_ff[31]}}, dn_ff}
              + {{2{rdata_ff[31]}}, rdata_ff} + {{2{left_ff[31]}}, left_ff};
   assign relax_val = sum[33:2];

   // write port select
   always_comb begin
      we    = 1'b0;
      waddr = ADDR_W'(cur_w);
      wdata = relax_val;
      if (cmd.host_write) begin
         we    = status.in_grid;
         waddr = status.in_grid ? ADDR_W'(req_w) : '0;
         wdata = wval_ff;
      end else if (cmd.init_write) begin
         we    = 1'b1;
         wdata = init_val;
      end else if (cmd.relax_write) begin
         we    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (cmd.read_sel != RS_NONE) rdata_ff <= mem[raddr];
   end

   // operand capture from the read data register, steered by the registered read select
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_q_ff <= RS_NONE;
      end else begin
         sel_q_ff <= cmd.read_sel;
      end
      case (sel_q_ff)
         RS_LEFT: left_ff <= rdata_ff;
         RS_UP:   up_ff   <= rdata_ff;
         RS_DOWN: dn_ff   <= rdata_ff;
         default: ;
      endcase
      if (cmd.relax_write) left_ff <= relax_val;
      if (cmd.capture) begin
         row_ff  <= req_row;
         col_ff  <= req_col;
         wval_ff <= req_write_value;
      end
   end

   // walk counters for init and sweep
   always_comb begin
      r_in    = r_ff;
      c_in    = c_ff;
      pass_in = pass_ff;
      if (cmd.init_first) begin
         r_in = '0;
         c_in = '0;
      end else if (cmd.sweep_first) begin
         r_in    = IDX_W'(1);
         c_in    = IDX_W'(1);
         pass_in = '0;
      end else if (cmd.init_write) begin
         if (c_w == n_w - 32'd1) begin
            c_in = '0;
            r_in = r_ff + IDX_W'(1);
         end else begin
            c_in = c_ff + IDX_W'(1);
         end
      end else if (cmd.relax_write) begin
         if (status.pass_cell_last) begin
            r_in    = IDX_W'(1);
            c_in    = IDX_W'(1);
            pass_in = pass_ff + 16'd1;
         end else if (status.row_end) begin
            c_in = IDX_W'(1);
            r_in = r_ff + IDX_W'(1);
         end else begin
            c_in = c_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_ff    <= '0;
         c_ff    <= '0;
         pass_ff <= '0;
      end else begin
         r_ff    <= r_in;
         c_ff    <= c_in;
         pass_ff <= pass_in;
      end
   end

   // result register
   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.rsp_load) begin
         rsp_kind_ff  <= cmd.rsp_kind;
         rsp_value_ff <= ((cmd.rsp_kind == RSP_READ) && status.in_grid) ? rdata_ff : CELL_ZERO;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_read_value  = rsp_value_ff;

endmodule
